### sv/crc16_record_seal_and_check_macros.svh
// assertion macros for the crc16 record seal and check block
`ifndef CRC16_RECORD_SEAL_AND_CHECK_MACROS_SVH
`define CRC16_RECORD_SEAL_AND_CHECK_MACROS_SVH

// same-cycle implication, disabled during reset
`define CRSC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define CRSC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/crsc_pkg.sv
// shared types, constants and crc function for the crc16 record block
`timescale 1ns / 1ps
`default_nettype none

package crsc_pkg;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;
   localparam logic [15:0] CRC_TOP  = 16'h8000;

   localparam logic [7:0] MAX_RECORD = 8'd253;
   localparam logic [7:0] RECORD_LENGTH_RESET = 8'd32;

   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 8;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_RECORD_LENGTH = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_CHECK_MODE    = 1'd1;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic [15:0] crc_value;
      logic        is_crc_byte;
      logic        end_of_record;
      logic        crc_match;
      logic        append_crc;
   } result_type;

   // byte-wide crc-16/ccitt-false update, msb first
   function automatic logic [15:0] crc16_update(input logic [15:0] crc_in,
                                                input logic [7:0]  data_in);
      logic [15:0] c;
      c = crc_in ^ {data_in, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if ((c & CRC_TOP) != 16'h0000) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

### sv/crsc_if.sv
// request and response channel interfaces for the crc16 record block
`timescale 1ns / 1ps
`default_nettype none

interface crsc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

interface crsc_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_byte;
   logic        is_crc_byte;
   logic        end_of_record;
   logic        crc_match;
   logic [15:0] crc_value;

   modport source (output valid, output out_byte, output is_crc_byte,
                   output end_of_record, output crc_match, output crc_value,
                   input ready);
   modport sink   (input valid, input out_byte, input is_crc_byte,
                   input end_of_record, input crc_match, input crc_value,
                   output ready);
endinterface

`default_nettype wire

### sv/crsc_core.sv
// record state, config registers and per-byte crc logic
`timescale 1ns / 1ps
`default_nettype none

module crsc_core (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_write_enable,
   input  wire logic [crsc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [crsc_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data,
   input  wire logic                                 accept,
   input  wire logic [7:0]                           data_byte,
   output crsc_pkg::result_type                      result
);

   logic [7:0]  record_length_ff, record_length_in;
   logic        check_mode_ff, check_mode_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  pos_ff, pos_in;
   logic [7:0]  rx_high_ff, rx_high_in;

   logic [7:0]  len_eff;
   logic [15:0] crc_next;
   logic [7:0]  pos_inc;
   logic        seal_last;

   always_comb begin
      record_length_in = record_length_ff;
      check_mode_in    = check_mode_ff;
      if (csr_write_enable) begin
         case (csr_index)
            crsc_pkg::REG_RECORD_LENGTH: record_length_in = csr_write_data[7:0];
            crsc_pkg::REG_CHECK_MODE:    check_mode_in    = csr_write_data[0];
            default: begin
               record_length_in = record_length_ff;
            end
         endcase
      end
   end

   always_comb begin
      if (record_length_ff == 8'd0) begin
         len_eff = 8'd1;
      end else if (record_length_ff > crsc_pkg::MAX_RECORD) begin
         len_eff = crsc_pkg::MAX_RECORD;
      end else begin
         len_eff = record_length_ff;
      end
   end

   assign crc_next  = crsc_pkg::crc16_update(crc_ff, data_byte);
   assign pos_inc   = pos_ff + 8'd1;
   assign seal_last = ({1'b0, pos_ff} + 9'd1) >= {1'b0, len_eff};

   always_comb begin
      crc_in     = crc_ff;
      pos_in     = pos_ff;
      rx_high_in = rx_high_ff;

      result.out_byte      = data_byte;
      result.crc_value     = crc_next;
      result.is_crc_byte   = 1'b0;
      result.end_of_record = 1'b0;
      result.crc_match     = 1'b1;
      result.append_crc    = 1'b0;

      if (!check_mode_ff) begin
         if (seal_last) begin
            result.append_crc = 1'b1;
            crc_in = crsc_pkg::CRC_INIT;
            pos_in = 8'd0;
         end else begin
            crc_in = crc_next;
            pos_in = pos_inc;
         end
      end else if (pos_ff < len_eff) begin
         result.crc_match = 1'b0;
         crc_in = crc_next;
         pos_in = pos_inc;
      end else if (pos_ff == len_eff) begin
         // received crc high byte, held for the compare on the low byte
         result.crc_value   = crc_ff;
         result.is_crc_byte = 1'b1;
         result.crc_match   = 1'b0;
         rx_high_in = data_byte;
         pos_in     = pos_inc;
      end else begin
         result.crc_value     = crc_ff;
         result.is_crc_byte   = 1'b1;
         result.end_of_record = 1'b1;
         result.crc_match     = ({rx_high_ff, data_byte} == crc_ff);
         crc_in = crsc_pkg::CRC_INIT;
         pos_in = 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         record_length_ff <= crsc_pkg::RECORD_LENGTH_RESET;
         check_mode_ff    <= 1'b0;
         crc_ff           <= crsc_pkg::CRC_INIT;
         pos_ff           <= 8'd0;
         rx_high_ff       <= 8'd0;
      end else begin
         record_length_ff <= record_length_in;
         check_mode_ff    <= check_mode_in;
         if (accept) begin
            crc_ff     <= crc_in;
            pos_ff     <= pos_in;
            rx_high_ff <= rx_high_in;
         end
      end
   end

endmodule

`default_nettype wire

### sv/crsc_out.sv
// result register that plays out one or three response transactions
`timescale 1ns / 1ps
`default_nettype none

module crsc_out (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  load_valid,
   input  wire crsc_pkg::result_type  load_result,
   output logic                       load_ready,
   crsc_rsp_if.source                 rsp
);

   typedef enum logic [2:0] {
      PHASE_DATA     = 3'b001,
      PHASE_CRC_HIGH = 3'b010,
      PHASE_CRC_LOW  = 3'b100
   } phase_type;

   logic                 valid_ff, valid_in;
   crsc_pkg::result_type result_ff, result_in;
   phase_type            phase_ff, phase_in;
   logic                 last_phase;

   assign last_phase = !result_ff.append_crc || (phase_ff == PHASE_CRC_LOW);
   // refill when empty or when the final transaction of the held item leaves
   assign load_ready = !valid_ff || (rsp.ready && last_phase);

   always_comb begin
      valid_in  = valid_ff;
      result_in = result_ff;
      phase_in  = phase_ff;
      if (load_ready) begin
         valid_in  = load_valid;
         result_in = load_result;
         phase_in  = PHASE_DATA;
      end else if (rsp.ready) begin
         case (phase_ff)
            PHASE_DATA:     phase_in = PHASE_CRC_HIGH;
            PHASE_CRC_HIGH: phase_in = PHASE_CRC_LOW;
            default:        phase_in = PHASE_DATA;
         endcase
      end
   end

   always_comb begin
      rsp.valid         = valid_ff;
      rsp.crc_value     = result_ff.crc_value;
      rsp.crc_match     = result_ff.crc_match;
      case (phase_ff)
         PHASE_CRC_HIGH: begin
            rsp.out_byte      = result_ff.crc_value[15:8];
            rsp.is_crc_byte   = 1'b1;
            rsp.end_of_record = 1'b0;
         end
         PHASE_CRC_LOW: begin
            rsp.out_byte      = result_ff.crc_value[7:0];
            rsp.is_crc_byte   = 1'b1;
            rsp.end_of_record = 1'b1;
         end
         default: begin
            rsp.out_byte      = result_ff.out_byte;
            rsp.is_crc_byte   = result_ff.is_crc_byte;
            rsp.end_of_record = result_ff.end_of_record;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= PHASE_DATA;
      end else begin
         valid_ff <= valid_in;
         phase_ff <= phase_in;
      end
      result_ff <= result_in;
   end

endmodule

`default_nettype wire

### sv/crc16_record_seal_and_check.sv
// crc-16/ccitt-false record sealer and checker, top level
//
// req carries one byte per transaction; rsp returns the echoed bytes, with
// crc bytes flagged and the last transaction of a record marked.
// seal mode (check_mode 0): record_length data bytes are echoed, and the
// last one is followed by the crc high byte and the crc low byte.
// check mode (check_mode 1): record_length data bytes and two received crc
// bytes are echoed; the low crc byte carries crc_match.
// an accepted byte is registered and shows on rsp in the following cycle.
// throughput: one byte per cycle while rsp is ready; the last data byte of a sealed record
// holds the result register for its two crc bytes as well, so req waits until they leave.
// the csr port writes record_length (index 0) and check_mode (index 1);
// write only between records while nothing is in flight.
// reset loads record_length 32, seal mode and a fresh crc of 0xffff.
// a stalled rsp holds its transaction and req.ready drops until it leaves.
`timescale 1ns / 1ps
`default_nettype none

`include "crc16_record_seal_and_check_macros.svh"

module crc16_record_seal_and_check (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   crsc_req_if.sink                                  req,
   crsc_rsp_if.source                                rsp,
   input  wire logic                                 csr_write_enable,
   input  wire logic [crsc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [crsc_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data
);

   crsc_pkg::result_type core_result;
   logic                 out_ready;
   logic                 accept;

   assign req.ready = out_ready;
   assign accept    = req.valid && out_ready;

   crsc_core u_core (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .accept           (accept),
      .data_byte        (req.data_byte),
      .result           (core_result)
   );

   crsc_out u_out (
      .clock       (clock),
      .reset       (reset),
      .load_valid  (req.valid),
      .load_result (core_result),
      .load_ready  (out_ready),
      .rsp         (rsp)
   );

   `CRSC_ASSERT_NOW(a_no_accept_while_stalled, clock, reset, rsp.valid && !rsp.ready, !req.ready, "request accepted while response stalled")
   `CRSC_ASSERT_NOW(a_end_is_crc, clock, reset, rsp.valid && rsp.end_of_record, rsp.is_crc_byte, "record end on a data byte")
   `CRSC_ASSERT_NOW(a_seal_high_byte, clock, reset, rsp.valid && rsp.is_crc_byte && rsp.crc_match && !rsp.end_of_record, rsp.out_byte == rsp.crc_value[15:8], "appended crc high byte wrong")

endmodule

`default_nettype wire

### tb/sv/crc16_record_seal_and_check_tb.sv
// self-checking testbench for the crc16 record seal and check block
`timescale 1ns / 1ps

module crc16_record_seal_and_check_tb;

   localparam int CYCLE_LIMIT = 500000;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        is_crc_byte;
      logic        end_of_record;
      logic        crc_match;
      logic [15:0] crc_value;
   } framed_byte_type;

   logic clock = 1'b0;
   logic reset;
   logic                                 csr_write_enable;
   logic [crsc_pkg::CSR_INDEX_WIDTH-1:0] csr_index;
   logic [crsc_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data;

   crsc_req_if req_if ();
   crsc_rsp_if rsp_if ();

   crc16_record_seal_and_check u_top (
      .clock            (clock),
      .reset            (reset),
      .req              (req_if),
      .rsp              (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #6 clock = ~clock;

   // framer state as the block should hold it
   logic [7:0]  model_len;
   logic        model_check;
   logic [15:0] model_crc;
   logic [7:0]  model_pos;
   logic [7:0]  model_crc_high;

   framed_byte_type expected_bytes[$];

   int cycle_count;
   int error_count;
   int items_sent;
   int results_checked;
   int sealed_records;
   int checked_records;
   int bad_crc_records;
   int idle_pct;
   int stall_pct;
   int stall_left;
   bit quiet;

   // bit-serial crc-16/ccitt-false, msb first
   function automatic logic [15:0] crc16_step(input logic [15:0] crc,
                                              input logic [7:0] b);
      logic [15:0] c;
      logic        fb;
      c = crc;
      for (int i = 7; i >= 0; i--) begin
         fb = c[15] ^ b[i];
         c  = {c[14:0], 1'b0} ^ (fb ? crsc_pkg::CRC_POLY : 16'h0000);
      end
      return c;
   endfunction

   // zero acts as one, anything above the maximum is clamped
   function automatic int record_span(input logic [7:0] len);
      if (len == 8'd0) return 1;
      if (len > crsc_pkg::MAX_RECORD) return int'(crsc_pkg::MAX_RECORD);
      return int'(len);
   endfunction

   function automatic void queue_result(input logic [7:0] b, input logic crc_flag,
                                        input logic eor, input logic match,
                                        input logic [15:0] crc);
      expected_bytes.push_back('{b, crc_flag, eor, match, crc});
   endfunction

   function automatic void reset_model();
      model_len      = crsc_pkg::RECORD_LENGTH_RESET;
      model_check    = 1'b0;
      model_crc      = crsc_pkg::CRC_INIT;
      model_pos      = 8'd0;
      model_crc_high = 8'd0;
   endfunction

   function automatic void predict_byte(input logic [7:0] b);
      int          span;
      logic [15:0] next_crc;
      logic        match;
      span = record_span(model_len);
      if (!model_check) begin
         next_crc = crc16_step(model_crc, b);
         queue_result(b, 1'b0, 1'b0, 1'b1, next_crc);
         if (int'(model_pos) + 1 >= span) begin
            queue_result(next_crc[15:8], 1'b1, 1'b0, 1'b1, next_crc);
            queue_result(next_crc[7:0], 1'b1, 1'b1, 1'b1, next_crc);
            model_crc = crsc_pkg::CRC_INIT;
            model_pos = 8'd0;
            sealed_records++;
         end else begin
            model_crc = next_crc;
            model_pos = model_pos + 8'd1;
         end
      end else if (int'(model_pos) < span) begin
         model_crc = crc16_step(model_crc, b);
         model_pos = model_pos + 8'd1;
         queue_result(b, 1'b0, 1'b0, 1'b0, model_crc);
      end else if (int'(model_pos) == span) begin
         model_crc_high = b;
         model_pos      = model_pos + 8'd1;
         queue_result(b, 1'b1, 1'b0, 1'b0, model_crc);
      end else begin
         // past the high crc byte: this is the low one, compared as it stands
         match = ({model_crc_high, b} == model_crc);
         queue_result(b, 1'b1, 1'b1, match, model_crc);
         model_crc = crsc_pkg::CRC_INIT;
         model_pos = 8'd0;
         checked_records++;
         if (!match) bad_crc_records++;
      end
   endfunction

   function automatic void flag_error(input string what, input framed_byte_type want,
                                      input framed_byte_type got);
      error_count++;
      if (error_count <= 10) begin
         $display("%0t %s: expected byte %02h crc_byte %0b eor %0b match %0b crc %04h",
                  $time, what, want.out_byte, want.is_crc_byte, want.end_of_record,
                  want.crc_match, want.crc_value);
         $display("%0t %s: got      byte %02h crc_byte %0b eor %0b match %0b crc %04h",
                  $time, what, got.out_byte, got.is_crc_byte, got.end_of_record,
                  got.crc_match, got.crc_value);
      end
   endfunction

   function automatic void check_result();
      framed_byte_type got;
      framed_byte_type want;
      got = '{rsp_if.out_byte, rsp_if.is_crc_byte, rsp_if.end_of_record,
              rsp_if.crc_match, rsp_if.crc_value};
      results_checked++;
      if (expected_bytes.size() == 0) begin
         flag_error("unexpected transaction", '0, got);
      end else begin
         want = expected_bytes.pop_front();
         if (got !== want) flag_error("mismatch", want, got);
      end
   endfunction

   // response side: check accepted transactions, stall in random bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) check_result();
         if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
            stall_left = $urandom_range(0, 17);
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  expected_bytes.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 9))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic int pick_idle_pct();
      case ($urandom_range(0, 2))
         0: return 0;
         1: return 15;
         default: return 40;
      endcase
   endfunction

   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = 0;
      if (!quiet && $urandom_range(0, 99) < idle_pct) gap = $urandom_range(1, 18);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.data_byte <= b;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      predict_byte(b);
      items_sent++;
   endtask

   // registers change only with nothing in flight; at least one is always written
   task automatic write_config(input bit set_len, input logic [7:0] len_value,
                               input bit set_mode, input bit mode_value);
      req_if.valid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
      if (set_len) begin
         csr_write_enable <= 1'b1;
         csr_index        <= crsc_pkg::REG_RECORD_LENGTH;
         csr_write_data   <= len_value;
         @(posedge clock);
         model_len = len_value;
      end
      if (set_mode) begin
         csr_write_enable <= 1'b1;
         csr_index        <= crsc_pkg::REG_CHECK_MODE;
         csr_write_data   <= {{(crsc_pkg::CSR_DATA_WIDTH-1){1'b0}}, mode_value};
         @(posedge clock);
         model_check = mode_value;
      end
      csr_write_enable <= 1'b0;
   endtask

   task automatic run_record(input bit mode, input logic [7:0] len, input bit corrupt);
      logic [15:0] crc;
      logic [7:0]  b;
      if (len != model_len || mode != model_check) write_config(1'b1, len, 1'b1, mode);
      crc = crsc_pkg::CRC_INIT;
      for (int i = 0; i < record_span(len); i++) begin
         b   = pick_byte();
         crc = crc16_step(crc, b);
         send_byte(b);
      end
      if (mode) begin
         if (corrupt) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
         send_byte(crc[15:8]);
         send_byte(crc[7:0]);
      end
   endtask

   // partial record, registers rewritten mid-record, then bytes until it closes
   task automatic broken_record(input bit mode, input logic [7:0] len);
      int k;
      if (len != model_len || mode != model_check) write_config(1'b1, len, 1'b1, mode);
      k = $urandom_range(1, record_span(len));
      repeat (k) send_byte(pick_byte());
      write_config(1'b1, 8'($urandom_range(0, 6)), $urandom_range(0, 1) == 0,
                   1'($urandom_range(0, 1)));
      while (model_pos != 8'd0) send_byte(pick_byte());
   endtask

   task automatic test_reset_defaults();
      // no register writes: a 32 byte sealed record
      repeat (32) send_byte(pick_byte());
   endtask

   task automatic test_directed_seal();
      write_config(1'b1, 8'd0, 1'b1, 1'b0);
      send_byte(8'h00);
      send_byte(8'hFF);
      // standard check string, crc 29b1
      write_config(1'b1, 8'd9, 1'b0, 1'b0);
      for (int i = 0; i < 9; i++) send_byte(8'h31 + 8'(i));
   endtask

   task automatic test_directed_check();
      logic [15:0] crc;
      write_config(1'b1, 8'd1, 1'b1, 1'b1);
      crc = crc16_step(crsc_pkg::CRC_INIT, 8'hA5);
      send_byte(8'hA5);
      send_byte(crc[15:8]);
      send_byte(crc[7:0]);
      crc = crc16_step(crsc_pkg::CRC_INIT, 8'h5A) ^ 16'h0001;
      send_byte(8'h5A);
      send_byte(crc[15:8]);
      send_byte(crc[7:0]);
   endtask

   task automatic test_mid_record_writes();
      write_config(1'b1, 8'd255, 1'b1, 1'b0);
      send_byte(8'h3C);
      send_byte(8'hC3);
      // position already past the new last byte, so the next byte seals
      write_config(1'b1, 8'd1, 1'b0, 1'b0);
      send_byte(8'h00);
      write_config(1'b1, 8'd4, 1'b0, 1'b0);
      repeat (3) send_byte(pick_byte());
      // switch to check mode past the high crc byte, stale high byte
      write_config(1'b1, 8'd2, 1'b1, 1'b1);
      send_byte(8'hFF);
   endtask

   task automatic test_random_records();
      int         start;
      bit         mode;
      logic [7:0] len;
      start = items_sent;
      while (items_sent - start < 50) begin
         idle_pct  = pick_idle_pct();
         stall_pct = pick_idle_pct();
         mode = 1'($urandom_range(0, 1));
         case ($urandom_range(0, 9))
            0: len = 8'd0;
            1: len = 8'd1;
            default: len = 8'($urandom_range(2, 12));
         endcase
         if ($urandom_range(0, 7) == 0) broken_record(mode, len);
         else run_record(mode, len, $urandom_range(0, 3) == 0);
      end
   endtask

   task automatic test_back_to_back();
      int start;
      quiet = 1'b1;
      start = items_sent;
      while (items_sent - start < 20)
         run_record(1'($urandom_range(0, 1)), 8'($urandom_range(1, 6)),
                    $urandom_range(0, 3) == 0);
   endtask

   initial begin
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.data_byte = 8'h00;
      rsp_if.ready     = 1'b0;
      csr_write_enable = 1'b0;
      csr_index        = '0;
      csr_write_data   = '0;
      quiet            = 1'b0;
      idle_pct         = 20;
      stall_pct        = 20;
      reset_model();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_directed_seal();
      test_directed_check();
      test_mid_record_writes();
      test_random_records();
      test_back_to_back();

      req_if.valid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      if (expected_bytes.size() != 0) begin
         $display("%0d expected transactions never arrived", expected_bytes.size());
         error_count += expected_bytes.size();
      end
      $display("sent %0d bytes, checked %0d transactions over %0d sealed and %0d checked records",
               items_sent, results_checked, sealed_records, checked_records);
      $display("%0d checked records carried a bad crc, %0d mismatches", bad_crc_records,
               error_count);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+sv
sv/crsc_pkg.sv
sv/crsc_if.sv
sv/crsc_core.sv
sv/crsc_out.sv
sv/crc16_record_seal_and_check.sv
tb/sv/crc16_record_seal_and_check_tb.sv
